### src/biquad_cascade_equalizer_core_defines.svh
// Assertion helpers for the equalizer core. Both expect clk and rst_n in scope.
`ifndef BIQUAD_CASCADE_EQUALIZER_CORE_DEFINES_SVH
`define BIQUAD_CASCADE_EQUALIZER_CORE_DEFINES_SVH

`ifndef SYNTH
`define BEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BEQ_ASSERT_IMP(lbl, ante, cons, msg)
`define BEQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### src/beq_pkg.sv
package beq_pkg;

  localparam int NUM_BANDS    = 8;
  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int COEF_FRAC    = COEF_BITS - 6;
  localparam int NUM_COEFS    = 5;

  localparam int IND_A0 = 0;
  localparam int IND_A1 = 1;
  localparam int IND_A2 = 2;
  localparam int IND_B1 = 3;
  localparam int IND_B2 = 4;

  // fixed field widths
  localparam int CHAN_W     = 3;
  localparam int BIDX_W     = 3;
  localparam int SLOT_W     = 3;
  localparam int ACT_W      = 4;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int BCNT_W = $clog2(NUM_BANDS + 1);
  localparam int HROWS  = NUM_BANDS * NUM_CHANNELS;
  localparam int HROW_W = (HROWS > 1) ? $clog2(HROWS) : 1;
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  // five products summed without overflow
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - 1;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_EQ_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_MASK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   load;
    logic                   rd;
    logic                   mul;
    logic [SLOT_W-1:0]      slot;
    logic                   fin;
    logic                   emit;
    logic [BAND_W-1:0]      band;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_t;

endpackage

### src/beq_ctrl.sv
module beq_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [beq_pkg::CHAN_W-1:0]         in_chan_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [beq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [beq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output beq_pkg::cmd_t                      cmd
);

  beq_pkg::state_t                 state_r, state_nxt;
  logic [beq_pkg::BCNT_W-1:0]      band_r, band_nxt;
  logic [beq_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            en_r;
  logic [beq_pkg::ACT_W-1:0]       act_r;
  logic [beq_pkg::MASK_W-1:0]      mask_r;

  logic [beq_pkg::BCNT_W-1:0]      n_eff;
  logic [beq_pkg::MASK_W-1:0]      mask_sh;
  logic                            bypass;
  logic                            chan_ok;

  assign n_eff   = (int'(act_r) > beq_pkg::NUM_BANDS) ? beq_pkg::BCNT_W'(beq_pkg::NUM_BANDS)
                                                      : beq_pkg::BCNT_W'(act_r);
  assign mask_sh = mask_r >> band_r;
  // bands above the mask width are never bypassed
  assign bypass  = (int'(band_r) < beq_pkg::MASK_W) && mask_sh[0];
  assign chan_ok = int'(in_chan_index) < beq_pkg::NUM_CHANNELS;

  assign in_ready  = (state_r == beq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= beq_pkg::ST_IDLE;
      band_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      band_r      <= band_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      act_r  <= '0;
      mask_r <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        beq_pkg::CFG_EQ_ENABLE:    en_r   <= cfg_data[0];
        beq_pkg::CFG_ACTIVE_BANDS: act_r  <= cfg_data[beq_pkg::ACT_W-1:0];
        beq_pkg::CFG_BYPASS_MASK:  mask_r <= cfg_data[beq_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    cmd.band  = band_r[beq_pkg::BAND_W-1:0];
    cmd.slot  = slot_r;
    case (state_r)
      beq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode == beq_pkg::OP_FILTER) begin
            band_nxt = '0;
            if (en_r && (act_r != '0) && chan_ok) begin
              state_nxt = beq_pkg::ST_SCAN;
            end else begin
              state_nxt = beq_pkg::ST_DONE;
            end
          end
        end
      end
      beq_pkg::ST_SCAN: begin
        if (band_r == n_eff) begin
          state_nxt = beq_pkg::ST_DONE;
        end else if (bypass) begin
          band_nxt = band_r + 1'b1;
        end else begin
          cmd.rd    = 1'b1;
          slot_nxt  = '0;
          state_nxt = beq_pkg::ST_MUL;
        end
      end
      beq_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        if (int'(slot_r) == beq_pkg::NUM_COEFS - 1) begin
          state_nxt = beq_pkg::ST_ACC;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      beq_pkg::ST_ACC: begin
        state_nxt = beq_pkg::ST_FIN;
      end
      beq_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        band_nxt  = band_r + 1'b1;
        state_nxt = beq_pkg::ST_SCAN;
      end
      beq_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = beq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = beq_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

endmodule

### src/beq_dp.sv
module beq_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  beq_pkg::cmd_t                          cmd,
  input  logic                                   in_opcode,
  input  logic [beq_pkg::CHAN_W-1:0]             in_chan_index,
  input  logic signed [beq_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic [beq_pkg::BIDX_W-1:0]             in_band_index,
  input  logic [beq_pkg::SLOT_W-1:0]             in_coef_slot,
  input  logic signed [beq_pkg::COEF_BITS-1:0]   in_coef_value,
  output logic signed [beq_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic [beq_pkg::CHAN_W-1:0]             out_chan_out,
  output logic                                   out_clipped
);

  logic signed [beq_pkg::COEF_BITS-1:0] coef_mem [beq_pkg::NUM_BANDS][beq_pkg::NUM_COEFS];
  beq_pkg::hist_t                       hist_mem [beq_pkg::HROWS];
  logic [beq_pkg::HROWS-1:0]            hist_vld_r;

  logic signed [beq_pkg::COEF_BITS-1:0]   coef_q_r [beq_pkg::NUM_COEFS];
  beq_pkg::hist_t                         hist_q_r;
  logic                                   hist_v_r;
  logic [beq_pkg::HROW_W-1:0]             hrow_r;
  logic signed [beq_pkg::SAMPLE_BITS-1:0] x_r;
  logic [beq_pkg::CHAN_W-1:0]             chan_r;
  logic                                   clip_r;
  logic signed [beq_pkg::PROD_W-1:0]      prod_r;
  logic                                   prod_v_r;
  logic                                   prod_sub_r;
  logic signed [beq_pkg::ACC_W-1:0]       acc_r;
  logic signed [beq_pkg::SAMPLE_BITS-1:0] out_sample_r;
  logic [beq_pkg::CHAN_W-1:0]             out_chan_r;
  logic                                   out_clip_r;

  logic [beq_pkg::HROW_W-1:0]             hrow;
  beq_pkg::hist_t                         h;
  logic signed [beq_pkg::SAMPLE_BITS-1:0] op_x;
  logic signed [beq_pkg::COEF_BITS-1:0]   op_c;
  logic signed [beq_pkg::ACC_W-1:0]       rnd;
  logic signed [beq_pkg::ACC_W-1:0]       shr;
  logic signed [beq_pkg::SAMPLE_BITS-1:0] y;
  logic                                   sat;
  logic                                   coef_we;

  assign hrow = beq_pkg::HROW_W'(int'(cmd.band) * beq_pkg::NUM_CHANNELS + int'(chan_r));
  // a row never written reads as zero history
  assign h    = hist_v_r ? hist_q_r : '0;
  assign op_c = coef_q_r[cmd.slot];

  always_comb begin
    case (cmd.slot)
      beq_pkg::SLOT_W'(beq_pkg::IND_A0): op_x = x_r;
      beq_pkg::SLOT_W'(beq_pkg::IND_A1): op_x = h.x1;
      beq_pkg::SLOT_W'(beq_pkg::IND_A2): op_x = h.x2;
      beq_pkg::SLOT_W'(beq_pkg::IND_B1): op_x = h.y1;
      beq_pkg::SLOT_W'(beq_pkg::IND_B2): op_x = h.y2;
      default:                           op_x = '0;
    endcase
  end

  // round half up, then clamp to the sample range
  always_comb begin
    rnd = acc_r + beq_pkg::RND_HALF;
    shr = rnd >>> beq_pkg::COEF_FRAC;
    if (shr > beq_pkg::SAT_HI) begin
      y   = beq_pkg::SAMPLE_BITS'(beq_pkg::SAT_HI);
      sat = 1'b1;
    end else if (shr < beq_pkg::SAT_LO) begin
      y   = beq_pkg::SAMPLE_BITS'(beq_pkg::SAT_LO);
      sat = 1'b1;
    end else begin
      y   = shr[beq_pkg::SAMPLE_BITS-1:0];
      sat = 1'b0;
    end
  end

  assign coef_we = cmd.load && (in_opcode == beq_pkg::OP_COEF)
                   && (int'(in_band_index) < beq_pkg::NUM_BANDS)
                   && (int'(in_coef_slot) < beq_pkg::NUM_COEFS);

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[beq_pkg::BAND_W'(in_band_index)][in_coef_slot] <= in_coef_value;
    end
    if (cmd.rd) begin
      coef_q_r <= coef_mem[cmd.band];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      hist_mem[hrow_r] <= '{x1: x_r, x2: h.x1, y1: y, y2: h.y1};
    end
    if (cmd.rd) begin
      hist_q_r <= hist_mem[hrow];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (cmd.fin) begin
      hist_vld_r[hrow_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      hist_v_r <= hist_vld_r[hrow];
      hrow_r   <= hrow;
    end
    prod_v_r <= cmd.mul;
    if (cmd.mul) begin
      prod_r     <= op_c * op_x;
      prod_sub_r <= (cmd.slot == beq_pkg::SLOT_W'(beq_pkg::IND_B1))
                 || (cmd.slot == beq_pkg::SLOT_W'(beq_pkg::IND_B2));
    end
    if (cmd.rd) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= prod_sub_r ? acc_r - beq_pkg::ACC_W'(prod_r)
                          : acc_r + beq_pkg::ACC_W'(prod_r);
    end
    if (cmd.load) begin
      x_r    <= in_sample_in;
      chan_r <= in_chan_index;
      clip_r <= 1'b0;
    end else if (cmd.fin) begin
      x_r    <= y;
      clip_r <= clip_r | sat;
    end
    if (cmd.emit) begin
      out_sample_r <= x_r;
      out_chan_r   <= chan_r;
      out_clip_r   <= clip_r;
    end
  end

  assign out_sample_out = out_sample_r;
  assign out_chan_out   = out_chan_r;
  assign out_clipped    = out_clip_r;

endmodule

### src/biquad_cascade_equalizer_core.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    opcode, chan_index, sample_in, band_index, coef_slot, coef_value
// out       out_valid / out_ready  sample_out, chan_out, clipped
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A coefficient request is written without leaving idle. A sample request steps through SCAN,
// MUL, ACC and FIN for each filtered band, skips bypassed ones in SCAN, or goes straight to DONE
// when passed through unchanged: one shared multiplier walks the five taps of a band.
// Reset clears control state, enable, band count and history valid bits and sets every bypass
// bit; coefficients are undefined. A finished result waits in the output register; the next
// request is taken meanwhile, and its result is held back until the output register is free.
`include "biquad_cascade_equalizer_core_defines.svh"

module biquad_cascade_equalizer_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_opcode,
  input  logic [beq_pkg::CHAN_W-1:0]             in_chan_index,
  input  logic signed [beq_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic [beq_pkg::BIDX_W-1:0]             in_band_index,
  input  logic [beq_pkg::SLOT_W-1:0]             in_coef_slot,
  input  logic signed [beq_pkg::COEF_BITS-1:0]   in_coef_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [beq_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic [beq_pkg::CHAN_W-1:0]             out_chan_out,
  output logic                                   out_clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [beq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [beq_pkg::CFG_DATA_W-1:0]         cfg_data
);

  beq_pkg::cmd_t cmd;

  beq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_chan_index (in_chan_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd)
  );

  beq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_opcode),
    .in_chan_index  (in_chan_index),
    .in_sample_in   (in_sample_in),
    .in_band_index  (in_band_index),
    .in_coef_slot   (in_coef_slot),
    .in_coef_value  (in_coef_value),
    .out_sample_out (out_sample_out),
    .out_chan_out   (out_chan_out),
    .out_clipped    (out_clipped)
  );

  `BEQ_ASSERT_IMP(a_busy_not_ready, cmd.rd || cmd.mul || cmd.fin, !in_ready, "request taken while filtering")
  `BEQ_ASSERT_IMP(a_no_overwrite, out_valid && !out_ready, !cmd.emit, "result overwritten before taken")
  `BEQ_ASSERT_NXT(a_coef_no_result, in_valid && in_ready && in_opcode, !cmd.emit, "coefficient request produced a result")

endmodule

### test/tb_biquad_cascade_equalizer_core.sv
`timescale 1ns / 1ps

module tb_biquad_cascade_equalizer_core;
  import beq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 113;
  localparam int SQUEEZE_CYCLES = 400;
  // index 3 maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic                          opcode;
    logic [CHAN_W-1:0]             chan;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [BIDX_W-1:0]             band;
    logic [SLOT_W-1:0]             slot;
    logic signed [COEF_BITS-1:0]   coef;
  } eq_req_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CHAN_W-1:0]             chan;
    logic                          clipped;
  } eq_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_FILTER;
  logic [CHAN_W-1:0] in_chan_index = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic [BIDX_W-1:0] in_band_index = '0;
  logic [SLOT_W-1:0] in_coef_slot = '0;
  logic signed [COEF_BITS-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic [CHAN_W-1:0] out_chan_out;
  logic out_clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  biquad_cascade_equalizer_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_chan_index (in_chan_index),
    .in_sample_in  (in_sample_in),
    .in_band_index (in_band_index),
    .in_coef_slot  (in_coef_slot),
    .in_coef_value (in_coef_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_chan_out  (out_chan_out),
    .out_clipped   (out_clipped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // equalizer state as seen from outside
  logic                          eq_on = 1'b0;
  logic [ACT_W-1:0]              band_count = '0;
  logic [MASK_W-1:0]             bypass_bits = '1;
  logic signed [COEF_BITS-1:0]   coefs[NUM_BANDS][NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] hx1[NUM_BANDS][NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] hx2[NUM_BANDS][NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] hy1[NUM_BANDS][NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] hy2[NUM_BANDS][NUM_CHANNELS];

  eq_req_t pending_reqs[$];
  eq_out_t expected_samples[$];
  eq_req_t in_flight;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int samples_checked = 0;
  int clipped_seen = 0;
  int coef_writes = 0;
  int reg_writes = 0;
  int cycle_cnt = 0;
  bit calm = 1'b0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  // Runs one sample through the active bands and advances the per-band history.
  function automatic eq_out_t run_cascade(logic [CHAN_W-1:0] ch,
                                          logic signed [SAMPLE_BITS-1:0] smp);
    eq_out_t o;
    logic signed [SAMPLE_BITS-1:0] x;
    longint acc;
    longint y;
    longint hi;
    int nb;
    hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    x = smp;
    o.clipped = 1'b0;
    nb = (band_count > NUM_BANDS) ? NUM_BANDS : int'(band_count);
    if (eq_on && nb != 0 && ch < NUM_CHANNELS) begin
      for (int b = 0; b < nb; b++) begin
        if (!(b < MASK_W && bypass_bits[b])) begin
          acc = longint'(coefs[b][IND_A0]) * longint'(x)
              + longint'(coefs[b][IND_A1]) * longint'(hx1[b][ch])
              + longint'(coefs[b][IND_A2]) * longint'(hx2[b][ch])
              - longint'(coefs[b][IND_B1]) * longint'(hy1[b][ch])
              - longint'(coefs[b][IND_B2]) * longint'(hy2[b][ch]);
          acc = acc + (longint'(1) << (COEF_FRAC - 1));
          y = acc >>> COEF_FRAC;
          if (y > hi) begin
            y = hi;
            o.clipped = 1'b1;
          end
          if (y < -hi - 1) begin
            y = -hi - 1;
            o.clipped = 1'b1;
          end
          hx2[b][ch] = hx1[b][ch];
          hx1[b][ch] = x;
          hy2[b][ch] = hy1[b][ch];
          hy1[b][ch] = y[SAMPLE_BITS-1:0];
          x = y[SAMPLE_BITS-1:0];
        end
      end
    end
    o.sample = x;
    o.chan = ch;
    return o;
  endfunction

  function automatic void take_request(eq_req_t r);
    if (r.opcode == OP_COEF) begin
      coef_writes++;
      if (r.band < NUM_BANDS && r.slot < NUM_COEFS) coefs[r.band][r.slot] = r.coef;
    end else begin
      expected_samples.push_back(run_cascade(r.chan, r.sample));
    end
  endfunction

  // Random filter values that keep each section stable.
  function automatic logic signed [COEF_BITS-1:0] mild_coef(int slot);
    int one;
    one = 1 << COEF_FRAC;
    case (slot)
      IND_A0: return COEF_BITS'($urandom_range(0, 2 * one) - one);
      IND_B2: return COEF_BITS'($urandom_range(0, one / 2) - one / 4);
      default: return COEF_BITS'($urandom_range(0, one) - one / 2);
    endcase
  endfunction

  function automatic eq_req_t noise_req();
    eq_req_t r;
    r.opcode = OP_FILTER;
    r.chan = CHAN_W'($urandom);
    r.sample = SAMPLE_BITS'($urandom);
    r.band = BIDX_W'($urandom);
    r.slot = SLOT_W'($urandom);
    r.coef = COEF_BITS'($urandom);
    return r;
  endfunction

  function automatic eq_req_t sample_req(int ch, logic signed [SAMPLE_BITS-1:0] v);
    eq_req_t r;
    r = noise_req();
    r.chan = CHAN_W'(ch);
    r.sample = v;
    return r;
  endfunction

  function automatic eq_req_t coef_req(int band, int slot, logic signed [COEF_BITS-1:0] v);
    eq_req_t r;
    r = noise_req();
    r.opcode = OP_COEF;
    r.band = BIDX_W'(band);
    r.slot = SLOT_W'(slot);
    r.coef = v;
    return r;
  endfunction

  function automatic eq_req_t random_req();
    eq_req_t r;
    int pick;
    r = noise_req();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.opcode = OP_COEF;
      r.slot = SLOT_W'($urandom_range(0, NUM_COEFS - 1));
      r.coef = mild_coef(int'(r.slot));
    end else if (pick < 13) begin
      // slot out of range, dropped by the block
      r.opcode = OP_COEF;
      r.slot = SLOT_W'($urandom_range(NUM_COEFS, (1 << SLOT_W) - 1));
    end else if (pick < 55) begin
      r.sample = SAMPLE_BITS'($urandom_range(0, 131071) - 65536);
    end
    return r;
  endfunction

  function automatic void push_req(eq_req_t r);
    pending_reqs.push_back(r);
    queued_cnt++;
  endfunction

  function automatic void push_coef_set(bit identity);
    for (int b = 0; b < NUM_BANDS; b++) begin
      for (int s = 0; s < NUM_COEFS; s++) begin
        if (identity) push_req(coef_req(b, s, (s == IND_A0) ? COEF_ONE : '0));
        else push_req(coef_req(b, s, mild_coef(s)));
      end
    end
  endfunction

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_EQ_ENABLE: eq_on = data[0];
      CFG_ACTIVE_BANDS: band_count = data[ACT_W-1:0];
      CFG_BYPASS_MASK: bypass_bits = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] en, logic [CFG_DATA_W-1:0] act,
                          logic [CFG_DATA_W-1:0] mask);
    write_reg(CFG_EQ_ENABLE, en);
    write_reg(CFG_ACTIVE_BANDS, act);
    write_reg(CFG_BYPASS_MASK, mask);
  endtask

  // request driver
  always @(posedge clk) begin : drive_proc
    int in_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_request(in_flight);
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_flight = pending_reqs.pop_front();
          in_opcode <= in_flight.opcode;
          in_chan_index <= in_flight.chan;
          in_sample_in <= in_flight.sample;
          in_band_index <= in_flight.band;
          in_coef_slot <= in_flight.slot;
          in_coef_value <= in_flight.coef;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, including one long hold-off
  always @(posedge clk) begin : ready_proc
    int hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left = SQUEEZE_CYCLES;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_proc
    eq_out_t exp_o;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("result with none pending: sample_out %0d chan_out %0d clipped %0b",
               out_sample_out, out_chan_out, out_clipped);
        err_cnt++;
      end else begin
        exp_o = expected_samples.pop_front();
        samples_checked++;
        if (exp_o.clipped) clipped_seen++;
        if (out_sample_out !== exp_o.sample) begin
          $error("sample_out: expected %0d, actual %0d", exp_o.sample, out_sample_out);
          err_cnt++;
        end
        if (out_chan_out !== exp_o.chan) begin
          $error("chan_out: expected %0d, actual %0d", exp_o.chan, out_chan_out);
          err_cnt++;
        end
        if (out_clipped !== exp_o.clipped) begin
          $error("clipped: expected %0b, actual %0b", exp_o.clipped, out_clipped);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL biquad_cascade_equalizer_core");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        hx1[b][c] = '0;
        hx2[b][c] = '0;
        hy1[b][c] = '0;
        hy2[b][c] = '0;
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

    // reset settings: plain pass-through
    push_req(sample_req(0, SMP_MAX));
    push_req(sample_req(7, SMP_MIN));
    push_req(sample_req(3, '0));
    push_req(sample_req(5, '1));
    push_req(coef_req(0, NUM_COEFS, COEF_MAX));
    push_req(coef_req(7, (1 << SLOT_W) - 1, COEF_MIN));
    push_coef_set(1'b1);
    push_req(coef_req(0, IND_A0, COEF_MAX));
    push_req(coef_req(1, IND_A0, COEF_MIN));
    wait_idle();

    // full cascade, extreme gains first, then back to unity
    set_regs(8'd1, 8'(NUM_BANDS), 8'h00);
    push_req(sample_req(1, 24'sd1));
    push_req(sample_req(2, SMP_MAX));
    push_req(sample_req(6, SMP_MIN));
    push_req(sample_req(4, '1));
    push_req(coef_req(0, IND_A0, COEF_ONE));
    push_req(coef_req(1, IND_A0, COEF_ONE));
    push_req(sample_req(2, SMP_MAX));
    push_req(sample_req(6, SMP_MIN));
    push_req(sample_req(0, '0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: set_regs(8'd1, 8'(NUM_BANDS), 8'h00);
        1: set_regs(8'd1, 8'd15, CFG_DATA_W'($urandom));
        2: set_regs(8'd1, 8'(NUM_BANDS), 8'h00);
        3: set_regs(8'hFE, 8'(NUM_BANDS), 8'h00);
        4: set_regs(8'd1, 8'd0, 8'h00);
        5: set_regs(8'd1, 8'(NUM_BANDS), 8'hFF);
        6: set_regs(8'd1, CFG_DATA_W'($urandom_range(1, NUM_BANDS)), CFG_DATA_W'($urandom));
        7: set_regs(8'd1, 8'hF4, 8'hAA);
        8: set_regs(8'd1, 8'd9, 8'h0F);
        default: set_regs(8'd1, 8'(NUM_BANDS), 8'h00);
      endcase
      if (ph % 3 == 0) push_coef_set(1'b0);
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_req(random_req());
      // all eight bands active here, so results are slow and the input backs up
      if (ph == 2) squeeze_req = 1'b1;
    end

    wait_idle();
    $display("Ran %0d requests over %0d register writes: %0d samples checked, %0d clipped,",
             accepted_cnt, reg_writes, samples_checked, clipped_seen);
    $display("%0d coefficient writes; bypass, pass-through and output stall covered.",
             coef_writes);
    if (err_cnt == 0) begin
      $display("PASS biquad_cascade_equalizer_core");
    end else begin
      $display("FAIL biquad_cascade_equalizer_core");
    end
    $finish;
  end

endmodule
